/* hw/rtl/ppt_pkg.sv */
// Shared types, register indexes and constants for the plane penetration test block.
package ppt_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_X  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Y  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Z  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_LIM = 3'd6;

    localparam logic signed [31:0] NORMAL_X_RESET = 32'sd65536;
    localparam logic [30:0]        LIMIT_RESET    = 31'd655360000;
    localparam logic signed [31:0] UNIT_ONE       = 32'sd1073741824;
    localparam logic signed [65:0] ROUND_HALF     = 66'sd536870912;
    localparam logic signed [31:0] SAT_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN        = 32'sh8000_0000;

    localparam logic UOP_SQRT = 1'b0;
    localparam logic UOP_DIV  = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } ppt_in_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [31:0] depth_change;
        logic               contact;
    } ppt_out_t;

    typedef struct packed {
        logic start;
        logic op;
    } ppt_unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ppt_unit_stat_t;

endpackage

/* hw/rtl/ppt_root_div.sv */
// Iterative unit that computes either an integer square root or an unsigned quotient.
module ppt_root_div import ppt_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  ppt_unit_req_t  req,
    input  logic [63:0]    radicand,
    input  logic [61:0]    numer,
    input  logic [31:0]    divisor,
    output ppt_unit_stat_t stat,
    output logic [31:0]    result
);

    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd30;

    logic        busy_reg;
    logic        done_reg;
    logic        op_reg;
    logic [4:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [63:0] src_reg;
    logic [31:0] root_reg;

    logic [34:0] cand;
    logic [34:0] trial;
    logic [35:0] diff;
    logic        ge;
    logic [34:0] rem_new;
    logic        last;

    always_comb begin
        if (op_reg == UOP_SQRT) begin
            cand  = {rem_reg[32:0], src_reg[63:62]};
            trial = {1'b0, root_reg, 2'b01};
            last  = (cnt_reg == SQRT_LAST);
        end else begin
            cand  = {2'b00, rem_reg[31:0], src_reg[30]};
            trial = {3'b000, root_reg};
            last  = (cnt_reg == DIV_LAST);
        end
        diff    = {1'b0, cand} - {1'b0, trial};
        ge      = ~diff[35];
        rem_new = ge ? diff[34:0] : cand;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= UOP_SQRT;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                if (req.op == UOP_SQRT) begin
                    rem_reg  <= '0;
                    src_reg  <= radicand;
                    root_reg <= '0;
                end else begin
                    rem_reg  <= {4'b0000, numer[61:31]};
                    src_reg  <= {33'd0, numer[30:0]};
                    root_reg <= divisor;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg + 5'd1;
                if (op_reg == UOP_SQRT) begin
                    root_reg <= {root_reg[30:0], ge};
                    src_reg  <= {src_reg[61:0], 2'b00};
                end else begin
                    src_reg <= {src_reg[63:31], src_reg[29:0], ge};
                end
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == UOP_SQRT) ? root_reg : {1'b0, src_reg[30:0]};

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("unit started while busy");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (op_reg == UOP_DIV) |-> (rem_reg < {3'b000, root_reg}))
        else $error("partial remainder not below divisor");

    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(busy_reg) |-> done_reg)
        else $error("operation ended without done");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done while still busy");

endmodule

/* hw/rtl/plane_penetration_test_core.sv */
// Top level of the plane penetration test: configuration, sequencer and datapath.
//
// Each input word on s_ is a point (pos_x, pos_y, pos_z) in signed Q16.16. Each
// result word on m_ carries the signed distance of the point from the configured
// plane, the change of that distance since the previous point, and a contact flag.
// The cfg_ channel writes the seven plane registers; it is always ready and should
// only be used while no point is in flight.
// The unit normal is cached. While the cache is valid a point goes from acceptance
// to m_valid through three multiply-accumulate passes on one shared multiplier,
// rounding and output, and a new point is taken only once the sequencer is idle.
// After reset or a write to a normal register, the next point first rebuilds the
// unit normal on the shared square-root and divide unit: normalizing shifts, 32
// root steps and three 31-step divides; a zero normal falls back to the x axis.
// Reset restores the register defaults, clears the previous depth and the cache.
// The result sits in an output register; a new point is accepted while it waits,
// and the sequencer holds its finished result until the register frees.
module plane_penetration_test_core import ppt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ppt_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ppt_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ABS       = 4'd1;
    localparam logic [3:0] ST_SHIFT     = 4'd2;
    localparam logic [3:0] ST_SQ        = 4'd3;
    localparam logic [3:0] ST_SQRT_GO   = 4'd4;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd5;
    localparam logic [3:0] ST_DIV_GO    = 4'd6;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd7;
    localparam logic [3:0] ST_DOT       = 4'd8;
    localparam logic [3:0] ST_RND       = 4'd9;
    localparam logic [3:0] ST_OUT       = 4'd10;

    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic signed [31:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [30:0]        limit_reg;
    logic               normal_wr;

    logic [3:0]         state_reg;
    logic [1:0]         cnt_reg;
    logic               unit_ok_reg;
    logic [31:0]        m0_reg, m1_reg, m2_reg;
    logic signed [31:0] u0_reg, u1_reg, u2_reg;
    logic signed [32:0] d0_reg, d1_reg, d2_reg;
    logic [31:0]        r_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] depth_reg;
    logic signed [31:0] prev_depth_reg;
    logic               m_valid_reg;
    ppt_out_t           m_data_reg;

    logic [31:0]        mag_x, mag_y, mag_z;
    logic [31:0]        sel_m;
    logic signed [31:0] sel_u;
    logic signed [32:0] sel_d;
    logic               sel_sign;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [61:0]        numer;
    logic [31:0]        q_pos, q_neg, u_new;
    logic signed [65:0] rnd_t;
    logic signed [35:0] rnd_sh;
    logic signed [31:0] depth_sat;
    logic signed [32:0] chg_full;
    logic signed [31:0] chg_sat;
    logic [31:0]        neg_mag;
    logic               contact;
    logic               out_free;

    ppt_unit_req_t      unit_req;
    ppt_unit_stat_t     unit_stat;
    logic [31:0]        unit_result;

    assign cfg_ready = 1'b1;
    assign normal_wr = cfg_valid && ((cfg_index == REG_NORMAL_X) ||
                       (cfg_index == REG_NORMAL_Y) || (cfg_index == REG_NORMAL_Z));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            normal_x_reg <= NORMAL_X_RESET;
            normal_y_reg <= '0;
            normal_z_reg <= '0;
            limit_reg    <= LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:  center_x_reg <= cfg_data;
                REG_CENTER_Y:  center_y_reg <= cfg_data;
                REG_CENTER_Z:  center_z_reg <= cfg_data;
                REG_NORMAL_X:  normal_x_reg <= cfg_data;
                REG_NORMAL_Y:  normal_y_reg <= cfg_data;
                REG_NORMAL_Z:  normal_z_reg <= cfg_data;
                REG_DEPTH_LIM: limit_reg    <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign mag_x = normal_x_reg[31] ? (~normal_x_reg + 32'd1) : normal_x_reg;
    assign mag_y = normal_y_reg[31] ? (~normal_y_reg + 32'd1) : normal_y_reg;
    assign mag_z = normal_z_reg[31] ? (~normal_z_reg + 32'd1) : normal_z_reg;

    always_comb begin
        unique case (cnt_reg)
            2'd0: begin
                sel_m = m0_reg; sel_u = u0_reg; sel_d = d0_reg; sel_sign = normal_x_reg[31];
            end
            2'd1: begin
                sel_m = m1_reg; sel_u = u1_reg; sel_d = d1_reg; sel_sign = normal_y_reg[31];
            end
            2'd2: begin
                sel_m = m2_reg; sel_u = u2_reg; sel_d = d2_reg; sel_sign = normal_z_reg[31];
            end
            default: begin
                sel_m = '0; sel_u = '0; sel_d = '0; sel_sign = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_SQ) begin
            mul_a = {2'b00, sel_m};
            mul_b = {2'b00, sel_m};
        end else begin
            mul_a = {{2{sel_u[31]}}, sel_u};
            mul_b = {sel_d[32], sel_d};
        end
        mul_p = mul_a * mul_b;
    end

    assign numer = {sel_m, 30'd0} + {31'd0, r_reg[31:1]};

    always_comb begin
        unit_req.start = (state_reg == ST_SQRT_GO) || (state_reg == ST_DIV_GO);
        unit_req.op    = (state_reg == ST_DIV_GO) ? UOP_DIV : UOP_SQRT;
    end

    ppt_root_div u_root_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (unit_req),
        .radicand (acc_reg[63:0]),
        .numer    (numer),
        .divisor  (r_reg),
        .stat     (unit_stat),
        .result   (unit_result)
    );

    assign q_pos = {1'b0, unit_result[30:0]};
    assign q_neg = ~q_pos + 32'd1;
    assign u_new = sel_sign ? q_neg : q_pos;

    always_comb begin
        rnd_t  = acc_reg + ROUND_HALF;
        rnd_sh = rnd_t[65:30];
        if ((rnd_sh[35:31] == 5'b00000) || (rnd_sh[35:31] == 5'b11111)) begin
            depth_sat = rnd_sh[31:0];
        end else begin
            depth_sat = rnd_sh[35] ? SAT_MIN : SAT_MAX;
        end
        chg_full = {depth_reg[31], depth_reg} - {prev_depth_reg[31], prev_depth_reg};
        if (chg_full[32] == chg_full[31]) begin
            chg_sat = chg_full[31:0];
        end else begin
            chg_sat = chg_full[32] ? SAT_MIN : SAT_MAX;
        end
        neg_mag = ~depth_reg + 32'd1;
        contact = depth_reg[31] && (neg_mag < {1'b0, limit_reg});
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            unit_ok_reg    <= 1'b0;
            prev_depth_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        d0_reg    <= {s_data.pos_x[31], s_data.pos_x} -
                                     {center_x_reg[31], center_x_reg};
                        d1_reg    <= {s_data.pos_y[31], s_data.pos_y} -
                                     {center_y_reg[31], center_y_reg};
                        d2_reg    <= {s_data.pos_z[31], s_data.pos_z} -
                                     {center_z_reg[31], center_z_reg};
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= unit_ok_reg ? ST_DOT : ST_ABS;
                    end
                end
                ST_ABS: begin
                    m0_reg <= mag_x;
                    m1_reg <= mag_y;
                    m2_reg <= mag_z;
                    if ((mag_x | mag_y | mag_z) == 32'd0) begin
                        u0_reg      <= UNIT_ONE;
                        u1_reg      <= '0;
                        u2_reg      <= '0;
                        unit_ok_reg <= 1'b1;
                        state_reg   <= ST_DOT;
                    end else begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (|{m0_reg[31:30], m1_reg[31:30], m2_reg[31:30]}) begin
                        state_reg <= ST_SQ;
                    end else begin
                        m0_reg <= {m0_reg[30:0], 1'b0};
                        m1_reg <= {m1_reg[30:0], 1'b0};
                        m2_reg <= {m2_reg[30:0], 1'b0};
                    end
                end
                ST_SQ: begin
                    prod_reg <= mul_p[63:0];
                    if (cnt_reg != 2'd0) begin
                        acc_reg <= acc_reg + {{2{prod_reg[63]}}, prod_reg};
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO: begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (unit_stat.done) begin
                        r_reg     <= unit_result;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (unit_stat.done) begin
                        unique case (cnt_reg)
                            2'd0:    u0_reg <= u_new;
                            2'd1:    u1_reg <= u_new;
                            default: u2_reg <= u_new;
                        endcase
                        if (cnt_reg == 2'd2) begin
                            unit_ok_reg <= 1'b1;
                            cnt_reg     <= '0;
                            acc_reg     <= '0;
                            state_reg   <= ST_DOT;
                        end else begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_DOT: begin
                    prod_reg <= mul_p[63:0];
                    if (cnt_reg != 2'd0) begin
                        acc_reg <= acc_reg + {{2{prod_reg[63]}}, prod_reg};
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= ST_RND;
                    end
                end
                ST_RND: begin
                    depth_reg <= depth_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg.depth        <= depth_reg;
                        m_data_reg.depth_change <= chg_sat;
                        m_data_reg.contact      <= contact;
                        m_valid_reg             <= 1'b1;
                        prev_depth_reg          <= depth_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (normal_wr) begin
                unit_ok_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cache_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && unit_ok_reg |=> (state_reg == ST_DOT))
        else $error("cached unit normal not used");

    a_normal_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && ((cfg_index == REG_NORMAL_X) ||
        (cfg_index == REG_NORMAL_Y) || (cfg_index == REG_NORMAL_Z)) |=> !unit_ok_reg)
        else $error("normal write did not drop the cached unit normal");

    a_contact_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.contact |-> m_data.depth[31])
        else $error("contact reported for a non-negative depth");

    a_prev_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.depth == prev_depth_reg))
        else $error("previous depth out of step with the pending word");

endmodule

/* tb/testbench.sv */
// Testbench for plane_penetration_test_core: directed and random points checked against a depth predictor.
`timescale 1ns / 100ps

module testbench;
    import ppt_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 200;
    localparam int RANDOM_PHASES    = 9;
    localparam int POINTS_PER_PHASE = 110;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } reg_write_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    ppt_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    ppt_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    logic signed [31:0] plane_center [3] = '{32'sd0, 32'sd0, 32'sd0};
    logic signed [31:0] plane_normal [3] = '{NORMAL_X_RESET, 32'sd0, 32'sd0};
    logic [30:0]        contact_limit    = LIMIT_RESET;
    logic signed [31:0] last_depth       = 32'sd0;

    ppt_in_t    point_q [$];
    reg_write_t reg_write_q [$];
    ppt_out_t   pending_depths [$];
    int         send_idle_pct = 16;
    int         recv_idle_pct = 67;
    int         errors        = 0;
    int         quiet_cycles  = 0;

    plane_penetration_test_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic signed [31:0] clamp32(logic signed [67:0] v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic ppt_out_t predict_result(ppt_in_t pt);
        logic [63:0]        mag [3];
        logic [63:0]        peak, rem, root, bitv, quo;
        logic signed [63:0] comp;
        logic signed [67:0] unit_v [3];
        logic signed [67:0] pos_v [3];
        logic signed [67:0] ctr, acc, prev, lim;
        logic signed [31:0] depth;
        ppt_out_t           res;
        peak = '0;
        for (int i = 0; i < 3; i++) begin
            comp = plane_normal[i];
            mag[i] = (comp < 0) ? -comp : comp;
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) begin
            unit_v[0] = UNIT_ONE;
            unit_v[1] = '0;
            unit_v[2] = '0;
        end else begin
            while (peak < 64'd1073741824) begin
                peak = peak << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            rem = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            root = '0;
            bitv = 64'd1 << 62;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            for (int i = 0; i < 3; i++) begin
                quo = ((mag[i] << 30) + (root >> 1)) / root;
                unit_v[i] = plane_normal[i][31] ? -$signed({4'd0, quo}) : $signed({4'd0, quo});
            end
        end
        pos_v[0] = $signed(pt.pos_x);
        pos_v[1] = $signed(pt.pos_y);
        pos_v[2] = $signed(pt.pos_z);
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            ctr = plane_center[i];
            acc = acc + unit_v[i] * (pos_v[i] - ctr);
        end
        depth = clamp32((acc + ROUND_HALF) >>> 30);
        acc = depth;
        prev = last_depth;
        lim = {37'd0, contact_limit};
        res.depth = depth;
        res.depth_change = clamp32(acc - prev);
        res.contact = (depth < 0) && (acc > -lim);
        last_depth = depth;
        return res;
    endfunction

    function automatic logic [31:0] mixed_word(int min_shift);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(31, min_shift);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [31:0] config_word();
        if ($urandom_range(3) == 0) return corner_word();
        return mixed_word(0);
    endfunction

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_q.push_back('{pos_x: x, pos_y: y, pos_z: z});
    endtask

    task automatic add_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        reg_write_q.push_back('{index: idx, data: value});
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (point_q.size() != 0 || s_valid || reg_write_q.size() != 0 || cfg_valid
               || pending_depths.size() != 0);
    endtask

    task automatic run_random_phase(int phase);
        logic [31:0] nrm [3];
        logic [30:0] lim;
        bit          zero_normal;
        zero_normal = ($urandom_range(7) == 0);
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(5))
                0: nrm[i] = '0;
                1: nrm[i] = corner_word();
                default: nrm[i] = mixed_word(0);
            endcase
            if (zero_normal) nrm[i] = '0;
        end
        case ($urandom_range(4))
            0: lim = '0;
            1: lim = 31'h7FFF_FFFF;
            default: lim = mixed_word(0);
        endcase
        add_write(REG_CENTER_X, config_word());
        add_write(REG_CENTER_Y, config_word());
        add_write(REG_CENTER_Z, config_word());
        add_write(REG_NORMAL_X, nrm[0]);
        add_write(REG_NORMAL_Y, nrm[1]);
        add_write(REG_NORMAL_Z, nrm[2]);
        add_write(REG_DEPTH_LIM, {1'($urandom_range(1)), lim});
        if ($urandom_range(2) == 0) add_write(REG_UNUSED, $urandom);
        wait_idle();
        for (int k = 0; k < POINTS_PER_PHASE; k++) begin
            // In phase 4, and at random in other phases, let the block drain completely before sending the second half.
            if (k == POINTS_PER_PHASE / 2 && (phase == 4 || $urandom_range(2) == 0))
                wait_idle();
            case ($urandom_range(9))
                0, 1, 2, 3: add_point(plane_center[0] + mixed_word(12),
                                      plane_center[1] + mixed_word(12),
                                      plane_center[2] + mixed_word(12));
                4, 5, 6: add_point($urandom, $urandom, $urandom);
                7, 8: add_point(mixed_word(0), mixed_word(0), mixed_word(0));
                default: add_point(corner_word(), corner_word(), corner_word());
            endcase
        end
        wait_idle();
    endtask

    always @(posedge aclk) begin : point_drive
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) pending_depths.push_back(predict_result(s_data));
            if (!s_valid || s_ready) begin
                if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= point_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : reg_drive
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_X:  plane_center[0] = cfg_data;
                    REG_CENTER_Y:  plane_center[1] = cfg_data;
                    REG_CENTER_Z:  plane_center[2] = cfg_data;
                    REG_NORMAL_X:  plane_normal[0] = cfg_data;
                    REG_NORMAL_Y:  plane_normal[1] = cfg_data;
                    REG_NORMAL_Z:  plane_normal[2] = cfg_data;
                    REG_DEPTH_LIM: contact_limit = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() != 0) begin
                    w = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        ppt_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_depths.size() == 0) begin
                    $error("result word with no point pending");
                    errors++;
                end else begin
                    want = pending_depths.pop_front();
                    if (m_data.depth !== want.depth) begin
                        $error("depth: expected %0d, got %0d", want.depth, m_data.depth);
                        errors++;
                    end
                    if (m_data.depth_change !== want.depth_change) begin
                        $error("depth_change: expected %0d, got %0d",
                               want.depth_change, m_data.depth_change);
                        errors++;
                    end
                    if (m_data.contact !== want.contact) begin
                        $error("contact: expected %0b, got %0b", want.contact, m_data.contact);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default plane: contact bounds and saturation of the depth change.
        add_point(32'h0, 32'h0, 32'h0);
        add_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_point(-32'sd655360000, 32'h0, 32'h0);
        add_point(-32'sd655359999, 32'h1234_5678, 32'h0);
        add_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        add_point(32'h8000_0000, 32'h0, 32'h0);
        add_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        add_write(REG_NORMAL_X, 32'h7FFF_FFFF);
        add_write(REG_NORMAL_Y, 32'h8000_0000);
        add_write(REG_NORMAL_Z, 32'h0000_0001);
        add_write(REG_CENTER_X, 32'h8000_0000);
        add_write(REG_CENTER_Y, 32'h7FFF_FFFF);
        add_write(REG_DEPTH_LIM, 32'hFFFF_FFFF);
        wait_idle();
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_idle();

        // A zero normal falls back to the x axis; a zero limit never reports contact.
        add_write(REG_NORMAL_X, 32'h0);
        add_write(REG_NORMAL_Y, 32'h0);
        add_write(REG_NORMAL_Z, 32'h0);
        add_write(REG_CENTER_X, 32'h0001_0000);
        add_write(REG_CENTER_Y, 32'h0);
        add_write(REG_DEPTH_LIM, 32'h0);
        add_write(REG_UNUSED, 32'hFFFF_FFFF);
        wait_idle();
        add_point(32'h0, 32'h0, 32'h0);
        add_point(32'h0001_0000, 32'h5, 32'h5);
        add_point(32'h0002_0000, 32'h0, 32'h0);
        wait_idle();

        // A tiny negative normal needs the largest normalizing shift.
        add_write(REG_CENTER_X, 32'h0);
        add_write(REG_NORMAL_Z, 32'hFFFF_FFFF);
        add_write(REG_DEPTH_LIM, 32'h0001_0000);
        wait_idle();
        add_point(32'h0, 32'h0, 32'h0000_8000);
        add_point(32'h0, 32'h0, 32'hFFFF_8000);
        add_point(32'h0, 32'h0, 32'h0001_0000);
        add_point(32'h0, 32'h0, 32'h0000_FFFF);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 16;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(p);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_root_div.sv
hw/rtl/plane_penetration_test_core.sv
tb/testbench.sv
